>>> rtl/bpar_pkg.sv
// bpar_pkg: shared types, constants and aes functions for the private address resolver
// no dependencies
`timescale 1ns / 1ps

package bpar_pkg;

    localparam int unsigned ROUNDS = 10;
    localparam int unsigned ADDR_W = 48;
    localparam int unsigned KEY_W = 128;
    localparam int unsigned HASH_W = 24;

    typedef logic [127:0] block_t;

    // one pipeline stage payload
    typedef struct packed {
        block_t      state;
        block_t      rkey;
        logic [23:0] addr_hash;
    } stage_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [ROUNDS] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // byte i of a block, byte 0 most significant
    function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
        return b[127 - 8*i -: 8];
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // next round key from the previous one
    function automatic block_t next_key(input block_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        begin
            w0 = k[127:96];
            w1 = k[95:64];
            w2 = k[63:32];
            w3 = k[31:0];
            t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
            w0 = w0 ^ t;
            w1 = w1 ^ w0;
            w2 = w2 ^ w1;
            w3 = w3 ^ w2;
            return {w0, w1, w2, w3};
        end
    endfunction

    // sub bytes, shift rows and optionally mix columns
    function automatic block_t round_fn(input block_t s, input logic mix);
        block_t t;
        logic [7:0] a0, a1, a2, a3, al;
        begin
            t = '0;
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    t[127 - 8*(r + 4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
                end
            end
            if (mix)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = get_byte(t, 4*c);
                    a1 = get_byte(t, 4*c + 1);
                    a2 = get_byte(t, 4*c + 2);
                    a3 = get_byte(t, 4*c + 3);
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[127 - 8*(4*c) -: 8]     = a0 ^ al ^ gf_double(a0 ^ a1);
                    t[127 - 8*(4*c + 1) -: 8] = a1 ^ al ^ gf_double(a1 ^ a2);
                    t[127 - 8*(4*c + 2) -: 8] = a2 ^ al ^ gf_double(a2 ^ a3);
                    t[127 - 8*(4*c + 3) -: 8] = a3 ^ al ^ gf_double(a3 ^ a0);
                end
            end
            return t;
        end
    endfunction

endpackage

>>> rtl/bpar_round.sv
// bpar_round: one aes round stage with its key expansion step and stall logic
// depends on bpar_pkg
`timescale 1ns / 1ps

module bpar_round
    import bpar_pkg::*;
#(
    parameter logic [7:0] RC = 8'h01,
    parameter bit LAST = 1'b0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  stage_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output stage_t out_data
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;
    block_t key_next;

    // stage advances when empty or downstream takes its beat
    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    // round logic
    always_comb
    begin
        key_next = next_key(in_data.rkey, RC);
        data_next.rkey = key_next;
        data_next.state = round_fn(in_data.state, !LAST) ^ key_next;
        data_next.addr_hash = in_data.addr_hash;
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("stalled round stage changed");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg)
        else $error("accepted beat lost in round stage");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_ready && !in_valid |=> !valid_reg)
        else $error("round stage repeated a beat");
`endif

endmodule

>>> rtl/ble_private_address_resolver_core.sv
// ble_private_address_resolver_core: top level, aes-128 hash of the random part, 10 round stages
// depends on bpar_pkg and bpar_round
`timescale 1ns / 1ps
//
// channel  | handshake           | payload
// in       | in_valid, in_ready  | address, key_high, key_low
// out      | out_valid, out_ready| computed_hash, match
//
// one beat per cycle in and out while out_ready is high; 10 round stages and a compare stage
// each round stage holds one aes round and one key expansion step
// reset clears only the stage valid bits
// a stall holds each full stage that has only full stages after it; empty stages still fill behind it

module ble_private_address_resolver_core
    import bpar_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [47:0] address,
    input  logic [63:0] key_high,
    input  logic [63:0] key_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] computed_hash,
    output logic        match
);

    stage_t sd   [ROUNDS + 1];
    logic   sv   [ROUNDS + 1];
    logic   sr   [ROUNDS + 1];

    logic        out_valid_reg;
    logic [23:0] hash_reg;
    logic        match_reg;
    logic        last_ready;

    // initial key addition
    assign sd[0] = '{
        state:     {104'd0, address[47:24]} ^ {key_high, key_low},
        rkey:      {key_high, key_low},
        addr_hash: address[23:0]
    };
    assign sv[0] = in_valid;
    assign in_ready = sr[0];

    // round stages
    for (genvar g = 0; g < ROUNDS; g++)
    begin : g_round
        bpar_round #(
            .RC   (RCON[g]),
            .LAST (g == ROUNDS - 1)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sv[g]),
            .in_ready  (sr[g]),
            .in_data   (sd[g]),
            .out_valid (sv[g + 1]),
            .out_ready (sr[g + 1]),
            .out_data  (sd[g + 1])
        );
    end

    // compare and output register
    assign last_ready = !out_valid_reg || out_ready;
    assign sr[ROUNDS] = last_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (last_ready)
        begin
            out_valid_reg <= sv[ROUNDS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_ready && sv[ROUNDS])
        begin
            hash_reg  <= sd[ROUNDS].state[23:0];
            match_reg <= (sd[ROUNDS].state[23:0] == sd[ROUNDS].addr_hash);
        end
    end

    assign out_valid = out_valid_reg;
    assign computed_hash = hash_reg;
    assign match = match_reg;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(computed_hash) && $stable(match))
        else $error("result changed while stalled");
    a_match: assert property (@(posedge clk) disable iff (!rst_n)
        sv[ROUNDS] && last_ready |=> match == (computed_hash == $past(sd[ROUNDS].addr_hash)))
        else $error("match flag disagrees with hash");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("pipeline stalled with free output");
`endif

endmodule
